### design/gcp_pkg.sv
// ----------------------------------------------------------------------------
// gcp_pkg: shared constants for the Gaussian collision probability block.
// Fixed-point constants of the log2-domain evaluation and the register map.
// ----------------------------------------------------------------------------
package gcp_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_PVAR_X = 2'd0;
  localparam logic [1:0] CFG_PVAR_Y = 2'd1;
  localparam logic [1:0] CFG_PVAR_Z = 2'd2;

  // Reset value of each point variance, 1.0 in Q16.16.
  localparam logic [31:0] PVAR_RESET = 32'd65536;

  // log2(e) in Q30.
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  // log2(0.267) - 1.5*log2(2pi) in Q16.16, plus 24.0 for the variance scale.
  localparam logic signed [37:0] EXP_BIAS = 38'sd1187359;

  // Capping thresholds in Q9.16.
  localparam logic [24:0] DEPTH_THR = 25'd64880;
  localparam logic [24:0] LASER_CAP = 25'd58982;
  localparam logic [24:0] PROB_CLAMP = 25'd16777216;

  // Sigmoid blend: 99.0 in Q30 and floor(2^30 / 100).
  localparam logic [36:0] SIG_BIAS = 37'd106300440576;
  localparam logic [23:0] RECIP_100 = 24'd10737418;

  // Chain of floor square roots from 2.0 in Q1.30, entry k is 2^(2^-k).
  function automatic logic [16:0][31:0] root_table();
    logic [16:0][31:0] t;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bt;
    t = '0;
    r = 64'd2147483648;
    t[0] = r[31:0];
    for (int k = 1; k <= 16; k++) begin
      x = r << 30;
      res = '0;
      bt = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
        if (x >= res + bt) begin
          x = x - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      r = res;
      t[k] = r[31:0];
    end
    return t;
  endfunction

  localparam logic [16:0][31:0] ROOT_TBL = root_table();

endpackage

### design/gaussian_collision_probability.sv
// ----------------------------------------------------------------------------
// gaussian_collision_probability: pipelined Gaussian collision evaluator.
// Computes the capped collision probability of a robot against one point.
// ----------------------------------------------------------------------------
// Usage:
//   Queries arrive on the in_ channel (valid/ready) with the robot position,
//   its per-axis variance, the nearest obstacle point, a found flag and the
//   capping mode. Each accepted transaction yields exactly one result
//   transaction on the out_ channel carrying the Q0.16 probability.
//   The point variances are to be written through cfg_we/cfg_index/cfg_wdata
//   only while the block is idle (not enforced by the block); indexes beyond
//   the last register are ignored. Throughput is one query per cycle while
//   the output is not stalled. The pipeline depth is set by the 33-step
//   restoring divider for the distance terms, two 16-step power-of-two
//   multiplier chains and the 31-step sigmoid divider, one stage per step.
//   The whole pipeline advances together: when out_valid is high and
//   out_ready is low, every stage holds and in_ready drops, so nothing is
//   lost or repeated. Reset clears all stage valid bits and restores each
//   point variance to 1.0.
module gaussian_collision_probability
  import gcp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic               in_point_found,
  input  logic signed [31:0] in_robot_x,
  input  logic signed [31:0] in_robot_y,
  input  logic signed [31:0] in_robot_z,
  input  logic [31:0]        in_robot_var_x,
  input  logic [31:0]        in_robot_var_y,
  input  logic [31:0]        in_robot_var_z,
  input  logic signed [31:0] in_near_x,
  input  logic signed [31:0] in_near_y,
  input  logic signed [31:0] in_near_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_probability
);

  // Stage schedule.
  localparam int ST_SQ   = 1;
  localparam int ST_SAT  = 2;
  localparam int ST_LOG0 = 2;
  localparam int ST_DIV0 = 3;
  localparam int ST_SUM  = 36;
  localparam int ST_AMUL = 37;
  localparam int ST_EXP  = 38;
  localparam int ST_P2A  = 39;
  localparam int ST_PSH  = 55;
  localparam int ST_XMUL = 56;
  localparam int ST_NEG  = 57;
  localparam int ST_P2B  = 58;
  localparam int ST_EVAL = 74;
  localparam int ST_DIVB = 75;
  localparam int ST_RMUL = 106;
  localparam int ST_OUT  = 107;
  localparam int DEPTH   = 108;

  typedef struct packed {
    logic                   vld;
    logic                   mode;
    logic                   found;
    logic [2:0][32:0]       ad;
    logic [2:0][32:0]       v;
    logic [2:0][65:0]       rem;
    logic [2:0][33:0]       q;
    logic [2:0][32:0]       lm;
    logic [2:0][5:0]        le;
    logic [2:0][15:0]       lf;
    logic [33:0]            s;
    logic [23:0]            lsum;
    logic [33:0]            a;
    logic signed [21:0]     pn;
    logic [15:0]            pf;
    logic [31:0]            pm;
    logic [24:0]            ps;
    logic [25:0]            x;
    logic signed [10:0]     n2;
    logic [15:0]            f2;
    logic [31:0]            pm2;
    logic [31:0]            dv;
    logic [60:0]            rem2;
    logic [30:0]            q2;
    logic [22:0]            y;
    logic [16:0]            q0;
    logic [15:0]            res;
  } stage_t;

  // One pipeline step; k selects the work done by that stage.
  function automatic stage_t stage_fn(input int k, input stage_t pr);
    stage_t o;
    logic [65:0] dvs;
    logic [63:0] mp;
    logic [32:0] r33;
    logic [35:0] s36;
    logic [23:0] ls;
    logic [64:0] ap;
    logic signed [37:0] l;
    logic signed [21:0] n;
    logic signed [21:0] shs;
    logic [63:0] sv;
    logic [55:0] xp;
    logic signed [26:0] ng;
    logic signed [10:0] nn;
    logic [31:0] e;
    logic [62:0] dv2;
    logic [36:0] ys;
    logic [46:0] yp;
    logic [23:0] rr;
    logic [16:0] qc;
    logic [15:0] sig;
    int b;
    o = pr;
    // Squared distance and leading-one normalization of the variance.
    if (k == ST_SQ) begin
      for (int i = 0; i < 3; i++) begin
        o.rem[i] = 66'(pr.ad[i]) * 66'(pr.ad[i]);
        o.le[i] = '0;
        for (int j = 0; j < 33; j++) begin
          if (pr.v[i][j]) o.le[i] = 6'(j);
        end
        if (o.le[i] == 6'd32) o.lm[i] = pr.v[i] >> 1;
        else o.lm[i] = pr.v[i] << (6'd31 - o.le[i]);
        o.lf[i] = '0;
      end
    end
    // Fraction bits of log2 by repeated squaring of the mantissa.
    if (k >= ST_LOG0 && k < ST_LOG0 + 16) begin
      for (int i = 0; i < 3; i++) begin
        mp = 64'(pr.lm[i][31:0]) * 64'(pr.lm[i][31:0]);
        r33 = mp[63:31];
        o.lf[i] = {pr.lf[i][14:0], r33[32]};
        o.lm[i] = r33[32] ? (r33 >> 1) : r33;
      end
    end
    // Quotient saturation check at 2^33.
    if (k == ST_SAT) begin
      for (int i = 0; i < 3; i++) begin
        dvs = {pr.v[i], 33'b0};
        if (pr.rem[i] >= dvs) begin
          o.q[i] = 34'd1 << 33;
          o.rem[i] = '0;
        end else begin
          o.q[i] = '0;
        end
      end
    end
    // One restoring division bit per stage.
    if (k >= ST_DIV0 && k <= ST_DIV0 + 32) begin
      b = ST_DIV0 + 32 - k;
      for (int i = 0; i < 3; i++) begin
        dvs = 66'(pr.v[i]) << b;
        if (pr.rem[i] >= dvs) begin
          o.rem[i] = pr.rem[i] - dvs;
          o.q[i] = pr.q[i] | (34'd1 << b);
        end
      end
    end
    // Saturating sum of the exponent terms and sum of the logarithms.
    if (k == ST_SUM) begin
      s36 = 36'(pr.q[0]) + 36'(pr.q[1]) + 36'(pr.q[2]);
      o.s = (s36 > (36'd1 << 33)) ? (34'd1 << 33) : s36[33:0];
      ls = 24'({pr.le[0], pr.lf[0]}) + 24'({pr.le[1], pr.lf[1]}) +
           24'({pr.le[2], pr.lf[2]});
      o.lsum = ls;
    end
    if (k == ST_AMUL) begin
      ap = 65'(pr.s) * 65'(LOG2E_Q30);
      o.a = ap[64:31];
    end
    // Exponent split into integer and fraction parts.
    if (k == ST_EXP) begin
      l = EXP_BIAS - $signed({15'b0, pr.lsum[23:1]}) - $signed({4'b0, pr.a});
      n = l[37:16];
      o.pn = (n > 22'sd32) ? 22'sd32 : n;
      o.pf = l[15:0];
      o.pm = 32'h4000_0000;
    end
    if (k >= ST_P2A && k < ST_P2A + 16) begin
      b = k - ST_P2A + 1;
      if (pr.pf[16 - b]) begin
        mp = 64'(pr.pm) * 64'(ROOT_TBL[5'(b)]);
        o.pm = mp[61:30];
      end
    end
    // Apply the integer exponent and clamp the probability.
    if (k == ST_PSH) begin
      if ($signed(pr.pn) < -22'sd61) begin
        o.ps = '0;
      end else begin
        shs = 22'sd46 - $signed(pr.pn);
        sv = {pr.pm, 32'b0} >> shs[6:0];
        o.ps = (sv > 64'(PROB_CLAMP)) ? PROB_CLAMP : sv[24:0];
      end
    end
    if (k == ST_XMUL) begin
      xp = 56'(pr.ps) * 56'(LOG2E_Q30);
      o.x = xp[55:30];
    end
    if (k == ST_NEG) begin
      ng = -$signed({1'b0, pr.x});
      o.n2 = ng[26:16];
      o.f2 = ng[15:0];
      o.pm2 = 32'h4000_0000;
    end
    if (k >= ST_P2B && k < ST_P2B + 16) begin
      b = k - ST_P2B + 1;
      if (pr.f2[16 - b]) begin
        mp = 64'(pr.pm2) * 64'(ROOT_TBL[5'(b)]);
        o.pm2 = mp[61:30];
      end
    end
    // Sigmoid denominator and divider start.
    if (k == ST_EVAL) begin
      if ($signed(pr.n2) <= -11'sd62) begin
        e = '0;
      end else begin
        nn = -$signed(pr.n2);
        e = pr.pm2 >> nn[5:0];
      end
      o.dv = 32'h4000_0000 + e;
      o.rem2 = 61'd1 << 60;
      o.q2 = '0;
    end
    if (k >= ST_DIVB && k <= ST_DIVB + 30) begin
      b = ST_DIVB + 30 - k;
      dv2 = 63'(pr.dv) << b;
      if ({2'b0, pr.rem2} >= dv2) begin
        o.rem2 = pr.rem2 - dv2[60:0];
        o.q2 = pr.q2 | (31'd1 << b);
      end
    end
    // Division by 100 through a reciprocal estimate.
    if (k == ST_RMUL) begin
      ys = SIG_BIAS + 37'(pr.q2);
      o.y = ys[36:14];
      yp = 47'(ys[36:14]) * 47'(RECIP_100);
      o.q0 = yp[46:30];
    end
    // Correction, capping and mode selection.
    if (k == ST_OUT) begin
      rr = 24'(pr.y) - 24'(pr.q0) * 24'd100;
      qc = pr.q0 + 17'(rr >= 24'd100);
      sig = (qc > 17'd65535) ? 16'hFFFF : qc[15:0];
      if (!pr.found) o.res = '0;
      else if (pr.mode) o.res = (pr.ps > LASER_CAP) ? LASER_CAP[15:0] : pr.ps[15:0];
      else o.res = (pr.ps > DEPTH_THR) ? sig : pr.ps[15:0];
    end
    return o;
  endfunction

  logic [31:0] pvar_r [3];
  stage_t      st0;
  stage_t      pipe_r   [DEPTH];
  stage_t      pipe_nxt [DEPTH];
  logic        adv;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvar_r[0] <= PVAR_RESET;
      pvar_r[1] <= PVAR_RESET;
      pvar_r[2] <= PVAR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PVAR_X: pvar_r[0] <= cfg_wdata;
        CFG_PVAR_Y: pvar_r[1] <= cfg_wdata;
        CFG_PVAR_Z: pvar_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The pipeline moves when the output slot is free or being taken.
  assign adv      = !pipe_r[DEPTH-1].vld || out_ready;
  assign in_ready = adv;

  // First stage: distance, its magnitude and the total variance.
  always_comb begin
    logic signed [32:0] d [3];
    logic [31:0] rp [3];
    logic [31:0] np [3];
    logic [31:0] rv [3];
    rp = '{in_robot_x, in_robot_y, in_robot_z};
    np = '{in_near_x, in_near_y, in_near_z};
    rv = '{in_robot_var_x, in_robot_var_y, in_robot_var_z};
    st0 = '0;
    st0.vld   = in_valid;
    st0.mode  = in_mode;
    st0.found = in_point_found;
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed({rp[i][31], rp[i]}) - $signed({np[i][31], np[i]});
      st0.ad[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
      st0.v[i] = {1'b0, rv[i]} + {1'b0, pvar_r[i]};
      if (st0.v[i] == '0) st0.v[i] = 33'd1;
    end
  end

  assign pipe_nxt[0] = st0;

  for (genvar g = 1; g < DEPTH; g++) begin : g_stage
    assign pipe_nxt[g] = stage_fn(g, pipe_r[g-1]);
  end

  // Stage registers; only the valid bits are reset.
  always_ff @(posedge clk) begin
    for (int k = 0; k < DEPTH; k++) begin
      if (!rst_n) pipe_r[k].vld <= 1'b0;
      else if (adv) pipe_r[k] <= pipe_nxt[k];
    end
  end

  assign out_valid       = pipe_r[DEPTH-1].vld;
  assign out_probability = pipe_r[DEPTH-1].res;

endmodule

### design/gcp_checker.sv
// ----------------------------------------------------------------------------
// gcp_checker: port-level checks for the collision probability block.
// Watches reset, flow control and result stability at the top level ports.
// ----------------------------------------------------------------------------
module gcp_checker
  import gcp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_probability
);

  // A result held by a stalled receiver keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_probability))
    else $error("result changed while stalled");

  // Nothing comes out right after reset.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The input side stalls exactly when a finished result is not taken.
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output flow");

  // An input transaction is never refused while the output moves.
  a_take_on_move: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && out_valid && out_ready |-> in_ready)
    else $error("input refused while output drains");

endmodule

bind gaussian_collision_probability gcp_checker u_gcp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_probability (out_probability)
);
